FILE: rtl/qdvs_pkg.sv
// ----------------------------------------------------------------------------
// qdvs_pkg
// Shared constants and types for the quadratic drag velocity step block:
// default widths, the configuration register map and lane count.
// ----------------------------------------------------------------------------
package qdvs_pkg;

    // default velocity word width and fixed point fraction bits
    localparam int VEL_WIDTH_DEF  = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // width of the density and step size registers
    localparam int COEF_W         = 32;

    // configuration port
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W_DEF = 32;

    // number of velocity axes
    localparam int AXES           = 3;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIND_X,
        CFG_WIND_Y,
        CFG_WIND_Z,
        CFG_AIR_DENSITY,
        CFG_STEP_SIZE
    } t_cfg_idx;

endpackage

FILE: rtl/qdvs_ifs.sv
// ----------------------------------------------------------------------------
// qdvs channel interfaces
// Valid/ready channels for velocity words in, result words out and
// configuration register writes.
// ----------------------------------------------------------------------------

// input velocity channel
interface qdvs_vel_if #(
    parameter int VEL_WIDTH = qdvs_pkg::VEL_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [VEL_WIDTH-1:0] vel_x;
    logic signed [VEL_WIDTH-1:0] vel_y;
    logic signed [VEL_WIDTH-1:0] vel_z;

    modport source (output valid, vel_x, vel_y, vel_z, input ready);
    modport sink   (input valid, vel_x, vel_y, vel_z, output ready);
endinterface

// result channel
interface qdvs_res_if #(
    parameter int VEL_WIDTH = qdvs_pkg::VEL_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [VEL_WIDTH-1:0] new_vel_x;
    logic signed [VEL_WIDTH-1:0] new_vel_y;
    logic signed [VEL_WIDTH-1:0] new_vel_z;
    logic                        fully_stopped;

    modport source (output valid, new_vel_x, new_vel_y, new_vel_z, fully_stopped,
                     input ready);
    modport sink   (input valid, new_vel_x, new_vel_y, new_vel_z, fully_stopped,
                     output ready);
endinterface

// configuration write channel
interface qdvs_cfg_if #(
    parameter int DATA_W = qdvs_pkg::CFG_DATA_W_DEF
);
    logic                             valid;
    logic                             ready;
    logic [qdvs_pkg::CFG_IDX_W-1:0]   index;
    logic [DATA_W-1:0]                data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/qdvs_front.sv
// ----------------------------------------------------------------------------
// qdvs_front
// Three stage front end: wind-relative velocity with saturation and
// magnitude, per-axis squares, and the sum of squares.
// ----------------------------------------------------------------------------
module qdvs_front #(
    parameter int VEL_WIDTH = qdvs_pkg::VEL_WIDTH_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_en,
    input  logic                                            i_vld,
    input  logic [qdvs_pkg::AXES-1:0][VEL_WIDTH-1:0]        i_vel,
    input  logic [qdvs_pkg::AXES-1:0][VEL_WIDTH-1:0]        i_wind,
    output logic                                            o_vld,
    output logic [2*VEL_WIDTH-1:0]                          o_rad,
    output logic [qdvs_pkg::AXES*(VEL_WIDTH+1)-1:0]         o_side
);
    import qdvs_pkg::*;

    localparam int LANE_W = VEL_WIDTH + 1;
    localparam int SQ_W   = 2 * VEL_WIDTH;
    localparam logic [VEL_WIDTH-1:0] V_MAX = {1'b0, {(VEL_WIDTH-1){1'b1}}};
    localparam logic [VEL_WIDTH-1:0] V_MIN = {1'b1, {(VEL_WIDTH-1){1'b0}}};

    // saturating signed subtract
    function automatic logic [VEL_WIDTH-1:0] sub_sat(input logic [VEL_WIDTH-1:0] a,
                                                     input logic [VEL_WIDTH-1:0] b);
        logic [VEL_WIDTH:0] d;
        d = {a[VEL_WIDTH-1], a} - {b[VEL_WIDTH-1], b};
        if (d[VEL_WIDTH] != d[VEL_WIDTH-1]) begin
            sub_sat = d[VEL_WIDTH] ? V_MIN : V_MAX;
        end else begin
            sub_sat = d[VEL_WIDTH-1:0];
        end
    endfunction

    logic [AXES-1:0][VEL_WIDTH-1:0] n_mag;
    logic [AXES-1:0]                n_neg;
    logic [AXES-1:0][VEL_WIDTH-1:0] r_mag;
    logic [AXES-1:0]                r_neg;
    logic [AXES-1:0][SQ_W-1:0]      r_sq;
    logic [AXES*LANE_W-1:0]         r_s2_side;
    logic [AXES*LANE_W-1:0]         r_s3_side;
    logic [SQ_W-1:0]                r_rad;
    logic                           r_s1_vld;
    logic                           r_s2_vld;
    logic                           r_s3_vld;

    // relative velocity, saturated, split into sign and magnitude
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            logic [VEL_WIDTH-1:0] rel;
            rel      = sub_sat(i_vel[a], i_wind[a]);
            n_neg[a] = rel[VEL_WIDTH-1];
            n_mag[a] = rel[VEL_WIDTH-1] ? VEL_WIDTH'(~rel + 1'b1) : rel;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= n_mag;
            r_neg <= n_neg;
            for (int a = 0; a < AXES; a++) begin
                r_sq[a]                    <= SQ_W'(r_mag[a]) * SQ_W'(r_mag[a]);
                r_s2_side[a*LANE_W +: LANE_W] <= {r_neg[a], r_mag[a]};
            end
            r_rad     <= r_sq[0] + r_sq[1] + r_sq[2];
            r_s3_side <= r_s2_side;
        end
    end

    assign o_vld  = r_s3_vld;
    assign o_rad  = r_rad;
    assign o_side = r_s3_side;

endmodule

FILE: rtl/qdvs_sqrt.sv
// ----------------------------------------------------------------------------
// qdvs_sqrt
// Pipelined digit-by-digit integer square root: one root bit per stage,
// floor of the exact root of the sum of squares.
// ----------------------------------------------------------------------------
module qdvs_sqrt #(
    parameter int VEL_WIDTH = qdvs_pkg::VEL_WIDTH_DEF,
    parameter int SIDE_W    = qdvs_pkg::AXES * (qdvs_pkg::VEL_WIDTH_DEF + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [2*VEL_WIDTH-1:0] i_rad,
    input  logic [SIDE_W-1:0]      i_side,
    output logic                   o_vld,
    output logic [VEL_WIDTH-1:0]   o_root,
    output logic [SIDE_W-1:0]      o_side
);
    import qdvs_pkg::*;

    localparam int NST   = VEL_WIDTH;
    localparam int RAD_W = 2 * VEL_WIDTH;

    logic [NST-1:0]       r_vld;
    logic [RAD_W-1:0]     r_rad  [NST];
    logic [VEL_WIDTH-1:0] r_rem  [NST];
    logic [VEL_WIDTH-1:0] r_root [NST];
    logic [SIDE_W-1:0]    r_side [NST];

    for (genvar g = 0; g < NST; g++) begin : g_stage
        logic                 vld_in;
        logic [RAD_W-1:0]     rad_in;
        logic [VEL_WIDTH-1:0] rem_in;
        logic [VEL_WIDTH-1:0] root_in;
        logic [SIDE_W-1:0]    side_in;
        logic [VEL_WIDTH+1:0] rem_sh;
        logic [VEL_WIDTH+1:0] trial;
        logic [VEL_WIDTH+1:0] rem_dif;
        logic                 ge;

        // stage inputs: the first stage starts from a zero root
        if (g == 0) begin : g_first
            assign vld_in  = i_vld;
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[g-1];
            assign rad_in  = r_rad[g-1];
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign side_in = r_side[g-1];
        end

        // bring down the next bit pair and try a one
        assign rem_sh  = {rem_in, rad_in[RAD_W-1 -: 2]};
        assign trial   = {root_in, 2'b01};
        assign ge      = (rem_sh >= trial);
        assign rem_dif = rem_sh - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[g]  <= rad_in << 2;
                r_rem[g]  <= ge ? rem_dif[VEL_WIDTH-1:0] : rem_sh[VEL_WIDTH-1:0];
                r_root[g] <= {root_in[VEL_WIDTH-2:0], ge};
                r_side[g] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[NST-1];
    assign o_root = r_root[NST-1];
    assign o_side = r_side[NST-1];

endmodule

FILE: rtl/qdvs_back.sv
// ----------------------------------------------------------------------------
// qdvs_back
// Back end: drag product from the length and the density-step coefficient,
// clamped retained fraction, per-axis scaling and wind add-back into the
// output register.
// ----------------------------------------------------------------------------
module qdvs_back #(
    parameter int VEL_WIDTH = qdvs_pkg::VEL_WIDTH_DEF,
    parameter int FRAC_BITS = qdvs_pkg::FRAC_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  logic                                        i_vld,
    input  logic [VEL_WIDTH-1:0]                        i_len,
    input  logic [qdvs_pkg::AXES*(VEL_WIDTH+1)-1:0]     i_side,
    input  logic [2*qdvs_pkg::COEF_W-1:0]               i_drag_coef,
    input  logic [qdvs_pkg::AXES-1:0][VEL_WIDTH-1:0]    i_wind,
    output logic                                        o_vld,
    output logic [qdvs_pkg::AXES-1:0][VEL_WIDTH-1:0]    o_new_vel,
    output logic                                        o_fully_stopped
);
    import qdvs_pkg::*;

    localparam int LANE_W = VEL_WIDTH + 1;
    localparam int SIDE_W = AXES * LANE_W;
    localparam int PP_W   = VEL_WIDTH + COEF_W;
    localparam int PROD_W = VEL_WIDTH + 2 * COEF_W;
    localparam int Q_W    = PROD_W - 2 * FRAC_BITS;
    localparam int FR_W   = FRAC_BITS + 1;
    localparam int SC_W   = VEL_WIDTH + FRAC_BITS;
    localparam logic [Q_W-1:0]       Q_ONE  = Q_W'(1) << FRAC_BITS;
    localparam logic [FR_W-1:0]      FR_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [VEL_WIDTH-1:0] V_MAX  = {1'b0, {(VEL_WIDTH-1){1'b1}}};
    localparam logic [VEL_WIDTH-1:0] V_MIN  = {1'b1, {(VEL_WIDTH-1){1'b0}}};

    logic                            r_b1_vld, r_b2_vld, r_b3_vld, r_b4_vld, r_out_vld;
    logic [PP_W-1:0]                 r_pp_lo;
    logic [PP_W-1:0]                 r_pp_hi;
    logic [SIDE_W-1:0]               r_b1_side, r_b2_side, r_b3_side;
    logic [PROD_W-1:0]               prod;
    logic [Q_W-1:0]                  r_q;
    logic                            stop;
    logic [FR_W-1:0]                 r_frac;
    logic                            r_b3_stop, r_b4_stop, r_out_stop;
    logic [AXES-1:0][SC_W-1:0]       r_sc;
    logic [AXES-1:0]                 r_b4_neg;
    logic [AXES-1:0][VEL_WIDTH-1:0]  n_new_vel;
    logic [AXES-1:0][VEL_WIDTH-1:0]  r_new_vel;

    // full drag product; the sum register drops twice the fraction bits from it
    assign prod = PROD_W'(r_pp_lo) + {r_pp_hi, COEF_W'(0)};

    // clamp test: product above one stops the body
    assign stop = (r_q > Q_ONE);

    // signed magnitude back to two's complement, add wind, saturate
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            logic [VEL_WIDTH-1:0] scaled;
            logic [VEL_WIDTH:0]   sval;
            logic [VEL_WIDTH+1:0] sum;
            scaled = r_sc[a][SC_W-1:FRAC_BITS];
            sval   = r_b4_neg[a] ? (LANE_W'(0) - {1'b0, scaled}) : {1'b0, scaled};
            sum    = {sval[VEL_WIDTH], sval}
                   + {i_wind[a][VEL_WIDTH-1], i_wind[a][VEL_WIDTH-1], i_wind[a]};
            if (sum[VEL_WIDTH+1] != sum[VEL_WIDTH] || sum[VEL_WIDTH] != sum[VEL_WIDTH-1]) begin
                n_new_vel[a] = sum[VEL_WIDTH+1] ? V_MIN : V_MAX;
            end else begin
                n_new_vel[a] = sum[VEL_WIDTH-1:0];
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld  <= 1'b0;
            r_b2_vld  <= 1'b0;
            r_b3_vld  <= 1'b0;
            r_b4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_b1_vld  <= i_vld;
            r_b2_vld  <= r_b1_vld;
            r_b3_vld  <= r_b2_vld;
            r_b4_vld  <= r_b3_vld;
            r_out_vld <= r_b4_vld;
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // partial products of length and coefficient halves
            r_pp_lo   <= PP_W'(i_len) * PP_W'(i_drag_coef[COEF_W-1:0]);
            r_pp_hi   <= PP_W'(i_len) * PP_W'(i_drag_coef[2*COEF_W-1:COEF_W]);
            r_b1_side <= i_side;
            // sum of partials
            r_q       <= prod[PROD_W-1:2*FRAC_BITS];
            r_b2_side <= r_b1_side;
            // retained fraction
            r_frac    <= stop ? '0 : (FR_ONE - r_q[FR_W-1:0]);
            r_b3_stop <= stop;
            r_b3_side <= r_b2_side;
            // per-axis scaling of the magnitude
            for (int a = 0; a < AXES; a++) begin
                r_sc[a]     <= SC_W'(r_b3_side[a*LANE_W +: VEL_WIDTH]) * SC_W'(r_frac);
                r_b4_neg[a] <= r_b3_side[a*LANE_W + VEL_WIDTH];
            end
            r_b4_stop <= r_b3_stop;
            // output register
            r_new_vel  <= n_new_vel;
            r_out_stop <= r_b4_stop;
        end
    end

    assign o_vld           = r_out_vld;
    assign o_new_vel       = r_new_vel;
    assign o_fully_stopped = r_out_stop;

endmodule

FILE: rtl/quadratic_drag_velocity_step_top.sv
// ----------------------------------------------------------------------------
// quadratic_drag_velocity_step_top
// One explicit Euler step of quadratic air drag on a body velocity, in
// signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one velocity word per clock and gives one result word per clock while
// the result side does not stall. The pipeline has three front stages, one
// square-root stage per root bit, and five back stages ending in the output
// register. The square root sets the depth. A stall on the result
// side holds the whole pipeline; input ready is high whenever the output
// register is empty or being taken. Configuration writes are always taken;
// change registers only while no word is in flight.
// ----------------------------------------------------------------------------
module quadratic_drag_velocity_step_top #(
    parameter int VEL_WIDTH = qdvs_pkg::VEL_WIDTH_DEF,
    parameter int FRAC_BITS = qdvs_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qdvs_vel_if.sink      i_vel,
    qdvs_res_if.source    o_res,
    qdvs_cfg_if.sink      i_cfg
);
    import qdvs_pkg::*;

    localparam int SIDE_W = AXES * (VEL_WIDTH + 1);
    localparam int DC_W   = 2 * COEF_W;
    localparam logic [COEF_W-1:0] STEP_RST = COEF_W'(((1 << FRAC_BITS) + 50) / 100);

    logic [AXES-1:0][VEL_WIDTH-1:0] r_wind;
    logic [COEF_W-1:0]              r_density;
    logic [COEF_W-1:0]              r_step;
    logic [DC_W-1:0]                r_drag_coef;
    logic [AXES-1:0][VEL_WIDTH-1:0] vel;
    logic                           en;
    logic                           fr_vld;
    logic [2*VEL_WIDTH-1:0]         fr_rad;
    logic [SIDE_W-1:0]              fr_side;
    logic                           sq_vld;
    logic [VEL_WIDTH-1:0]           sq_root;
    logic [SIDE_W-1:0]              sq_side;
    logic                           bk_vld;
    logic [AXES-1:0][VEL_WIDTH-1:0] bk_new_vel;
    logic                           bk_stop;

    // pipeline advance: output register empty or being taken
    assign en          = !bk_vld || o_res.ready;
    assign i_vel.ready = en;
    assign i_cfg.ready = 1'b1;

    assign vel[0] = i_vel.vel_x;
    assign vel[1] = i_vel.vel_y;
    assign vel[2] = i_vel.vel_z;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wind    <= '0;
            r_density <= '0;
            r_step    <= STEP_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_WIND_X:      r_wind[0] <= i_cfg.data[VEL_WIDTH-1:0];
                CFG_WIND_Y:      r_wind[1] <= i_cfg.data[VEL_WIDTH-1:0];
                CFG_WIND_Z:      r_wind[2] <= i_cfg.data[VEL_WIDTH-1:0];
                CFG_AIR_DENSITY: r_density <= i_cfg.data[COEF_W-1:0];
                CFG_STEP_SIZE:   r_step    <= i_cfg.data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // density times step, settled long before a word reaches the back end
    always_ff @(posedge i_clk) begin
        r_drag_coef <= DC_W'(r_density) * DC_W'(r_step);
    end

    qdvs_front #(
        .VEL_WIDTH (VEL_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_vel.valid),
        .i_vel   (vel),
        .i_wind  (r_wind),
        .o_vld   (fr_vld),
        .o_rad   (fr_rad),
        .o_side  (fr_side)
    );

    qdvs_sqrt #(
        .VEL_WIDTH (VEL_WIDTH),
        .SIDE_W    (SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (fr_vld),
        .i_rad   (fr_rad),
        .i_side  (fr_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    qdvs_back #(
        .VEL_WIDTH (VEL_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_vld           (sq_vld),
        .i_len           (sq_root),
        .i_side          (sq_side),
        .i_drag_coef     (r_drag_coef),
        .i_wind          (r_wind),
        .o_vld           (bk_vld),
        .o_new_vel       (bk_new_vel),
        .o_fully_stopped (bk_stop)
    );

    // result word
    assign o_res.valid         = bk_vld;
    assign o_res.new_vel_x     = bk_new_vel[0];
    assign o_res.new_vel_y     = bk_new_vel[1];
    assign o_res.new_vel_z     = bk_new_vel[2];
    assign o_res.fully_stopped = bk_stop;

endmodule
